// ===== rtl/plb_pkg.sv =====
package plb_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    MODE_INS_HEAD  = 3'd0,
    MODE_INS_TAIL  = 3'd1,
    MODE_INS_AFTER = 3'd2,
    MODE_LOOKUP    = 3'd3,
    MODE_DEL_FIRST = 3'd4,
    MODE_DEL_LAST  = 3'd5,
    MODE_DEL_AT    = 3'd6,
    MODE_LENGTH    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOPOS = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      idx;
    logic [ITEM_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/plb_cell.sv =====
module plb_cell
  import plb_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      cell_idx,
  input  cell_cmd_t             cmd,
  input  logic [ITEM_WIDTH-1:0] prev_item,
  input  logic [ITEM_WIDTH-1:0] next_item,
  output logic [ITEM_WIDTH-1:0] item,
  output logic [ITEM_WIDTH-1:0] hit_item
);

  logic [ITEM_WIDTH-1:0] item_next;

  always_comb begin
    item_next = item;
    unique case (cmd.op)
      OP_INS: begin
        if (cell_idx > cmd.idx) begin
          item_next = prev_item;
        end else if (cell_idx == cmd.idx) begin
          item_next = cmd.value;
        end
      end
      OP_DEL: begin
        if (cell_idx >= cmd.idx) begin
          item_next = next_item;
        end
      end
      default: item_next = item;
    endcase
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

  assign hit_item = (cell_idx == cmd.idx) ? item : '0;

endmodule

// ===== rtl/positional_list_buffer.sv =====
// channel   signals                                     direction
// request   in_valid, in_stall, mode, position,         in
//           item_value
// result    out_valid, out_stall, item_out, status,     out
//           length
//
// One request per cycle unless in_stall; result shows the cycle after acceptance.
// In an insert or delete, the CAPACITY cells shift the entries from the target on.
// Reset (rst, synchronous) empties the list and drops any pending result.
// in_stall is high only while a result waits and out_stall holds it.
module positional_list_buffer
  import plb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [5:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] item_out,
  output logic [1:0]  status,
  output logic [6:0]  length
);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  empty;
  logic                  full;
  logic [CNT_W-1:0]      pos_ext;
  logic [CNT_W-1:0]      tgt;
  cell_op_t              op;
  status_t               st;
  logic                  found_ok;
  cell_cmd_t             cmd;
  logic [ITEM_WIDTH-1:0] cell_item [CAPACITY];
  logic [ITEM_WIDTH-1:0] cell_hit  [CAPACITY];
  logic [ITEM_WIDTH-1:0] hit_or;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(CAPACITY));
  assign pos_ext  = CNT_W'(position);

  always_comb begin
    tgt      = '0;
    op       = OP_HOLD;
    st       = ST_OK;
    found_ok = 1'b0;
    unique case (mode_t'(mode))
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AFTER: begin
        if (mode_t'(mode) == MODE_INS_TAIL) begin
          tgt = count;
        end else if (mode_t'(mode) == MODE_INS_AFTER && !empty) begin
          tgt = (pos_ext < count) ? pos_ext + CNT_W'(1) : count;
        end
        if (full) begin
          st = ST_FULL;
        end else begin
          op = OP_INS;
        end
      end
      MODE_LOOKUP: begin
        tgt = pos_ext;
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= count) begin
          st = ST_NOPOS;
        end else begin
          found_ok = 1'b1;
        end
      end
      MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_AT: begin
        if (mode_t'(mode) == MODE_DEL_LAST) begin
          tgt = count - CNT_W'(1);
        end else if (mode_t'(mode) == MODE_DEL_AT) begin
          tgt = pos_ext;
        end
        if (empty) begin
          st = ST_EMPTY;
        end else if (tgt >= count) begin
          st = ST_NOPOS;
        end else begin
          op = OP_DEL;
        end
      end
      MODE_LENGTH: st = ST_OK;
    endcase
  end

  assign cmd.op    = accept ? op : OP_HOLD;
  assign cmd.idx   = IDX_W'(tgt);
  assign cmd.value = ITEM_WIDTH'(item_value);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plb_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .prev_item ((g == 0) ? '0 : cell_item[(g == 0) ? 0 : g - 1]),
      .next_item ((g == CAPACITY - 1) ? '0 : cell_item[(g == CAPACITY - 1) ? g : g + 1]),
      .item      (cell_item[g]),
      .hit_item  (cell_hit[g])
    );
  end

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_or = hit_or | cell_hit[i];
    end
  end

  always_comb begin
    count_next = count;
    if (accept && op == OP_INS) begin
      count_next = count + CNT_W'(1);
    end else if (accept && op == OP_DEL) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      item_out <= found_ok ? 32'(hit_or) : 32'd0;
      status   <= st;
      length   <= 7'(count_next);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_length_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (CNT_W'(length) == count))
    else $error("reported length differs from stored count");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && full && (mode == MODE_INS_HEAD || mode == MODE_INS_TAIL ||
                       mode == MODE_INS_AFTER)
    |=> (status == ST_FULL) && $stable(count))
    else $error("insert into full list not refused");

  a_item_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (item_out != 32'd0) |-> (status == ST_OK))
    else $error("item returned with failing status");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import plb_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int PRINT_LIMIT = 30;

  typedef struct {
    logic [ITEM_WIDTH-1:0] item;
    status_t               st;
    logic [CNT_W-1:0]      len;
  } list_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [2:0]  mode       = '0;
  logic [5:0]  position   = '0;
  logic [31:0] item_value = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] item_out;
  logic [1:0]  status;
  logic [6:0]  length;

  logic [ITEM_WIDTH-1:0] shadow_items [CAPACITY];
  int                    shadow_count = 0;
  list_result_t          awaited_results [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  stall_style_t          stall_style = STALL_NONE;
  int                    stall_run = 0;

  positional_list_buffer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .position   (position),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .item_out   (item_out),
    .status     (status),
    .length     (length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("positional_list_buffer verification failed");
      $finish;
    end
  end

  function automatic status_t drop_entry(int idx);
    int i;
    if (shadow_count == 0) return ST_EMPTY;
    if (idx >= shadow_count) return ST_NOPOS;
    for (i = idx; i < shadow_count - 1; i++) shadow_items[i] = shadow_items[i + 1];
    shadow_count--;
    return ST_OK;
  endfunction

  function automatic list_result_t compute_list_outcome(mode_t m, logic [5:0] p,
                                                        logic [31:0] v);
    list_result_t r;
    int           slot;
    int           i;
    r.item = '0;
    r.st   = ST_OK;
    slot   = -1;
    case (m)
      MODE_INS_HEAD: slot = 0;
      MODE_INS_TAIL: slot = shadow_count;
      MODE_INS_AFTER: begin
        if (shadow_count == 0) slot = 0;
        else slot = ((int'(p) < shadow_count) ? int'(p) : shadow_count - 1) + 1;
      end
      MODE_LOOKUP: begin
        if (shadow_count == 0) r.st = ST_EMPTY;
        else if (int'(p) >= shadow_count) r.st = ST_NOPOS;
        else r.item = shadow_items[p];
      end
      MODE_DEL_FIRST: r.st = drop_entry(0);
      MODE_DEL_LAST:  r.st = drop_entry(shadow_count - 1);
      MODE_DEL_AT:    r.st = drop_entry(int'(p));
      default: ;
    endcase
    if (slot >= 0) begin
      if (shadow_count >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        for (i = shadow_count; i > slot; i--) shadow_items[i] = shadow_items[i - 1];
        shadow_items[slot] = v;
        shadow_count++;
      end
    end
    r.len = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_count, what, want, got);
  endtask

  task automatic send_request(mode_t m, logic [5:0] p, logic [31:0] v);
    int gap;
    in_valid   <= 1'b1;
    mode       <= m;
    position   <= p;
    item_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_results.push_back(compute_list_outcome(m, p, v));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(0, 8);
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request pending", '0, item_out);
      end else begin
        want = awaited_results.pop_front();
        if (item_out !== want.item) report_mismatch("item_out", want.item, item_out);
        if (status !== want.st) report_mismatch("status", 32'(want.st), 32'(status));
        if (length !== want.len) report_mismatch("length", 32'(want.len), 32'(length));
      end
    end
    if (stall_run == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_run   = $urandom_range(20, 80);
    end
    stall_run--;
    case (stall_style)
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((stall_run % 5) < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  task automatic test_empty_list();
    send_request(MODE_LOOKUP, 6'd0, 32'h0);
    send_request(MODE_LOOKUP, 6'd63, 32'hFFFF_FFFF);
    send_request(MODE_DEL_FIRST, 6'd0, 32'h0);
    send_request(MODE_DEL_LAST, 6'd63, 32'h0);
    send_request(MODE_DEL_AT, 6'd0, 32'h0);
    send_request(MODE_LENGTH, 6'd0, 32'h0);
  endtask

  task automatic test_insert_placement();
    int i;
    send_request(MODE_INS_AFTER, 6'd63, 32'h0000_0001);
    send_request(MODE_INS_HEAD, 6'd0, 32'h0000_0000);
    send_request(MODE_INS_TAIL, 6'd0, 32'hFFFF_FFFF);
    send_request(MODE_INS_AFTER, 6'd0, 32'hA5A5_A5A5);
    send_request(MODE_INS_AFTER, 6'd63, 32'h5A5A_5A5A);
    for (i = 0; i <= 5; i++) send_request(MODE_LOOKUP, 6'(i), 32'h0);
    send_request(MODE_LENGTH, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_delete_placement();
    send_request(MODE_DEL_AT, 6'd63, 32'h0);
    send_request(MODE_DEL_AT, 6'd2, 32'h0);
    send_request(MODE_DEL_FIRST, 6'd0, 32'h0);
    send_request(MODE_DEL_LAST, 6'd0, 32'h0);
    send_request(MODE_LOOKUP, 6'd0, 32'h0);
    send_request(MODE_LOOKUP, 6'd1, 32'h0);
  endtask

  task automatic send_random_request(traffic_mix_t mix);
    int          pick;
    int          top;
    mode_t       m;
    logic [5:0]  p;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (pick < 80) m = mode_t'($urandom_range(0, 2));
        else if (pick < 92) m = MODE_LOOKUP;
        else m = mode_t'($urandom_range(4, 7));
      end
      MIX_SHRINK: begin
        if (pick < 70) m = mode_t'($urandom_range(4, 6));
        else if (pick < 85) m = MODE_LOOKUP;
        else if (pick < 93) m = mode_t'($urandom_range(0, 2));
        else m = MODE_LENGTH;
      end
      default: m = mode_t'($urandom_range(0, 7));
    endcase
    top = (shadow_count > 63) ? 63 : shadow_count;
    if ($urandom_range(0, 9) < 7) p = 6'($urandom_range(0, top));
    else p = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 9);
    if (pick == 0) v = '0;
    else if (pick == 1) v = '1;
    else v = $urandom();
    send_request(m, p, v);
  endtask

  task automatic test_random_traffic();
    traffic_mix_t plan [7] = '{MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_GROW,
                               MIX_EVEN, MIX_SHRINK, MIX_EVEN};
    int           plan_len [7] = '{110, 80, 110, 110, 100, 60, 80};
    int           k;
    int           n;
    for (k = 0; k < 7; k++)
      for (n = 0; n < plan_len[k]; n++) send_random_request(plan[k]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_insert_placement();
    test_delete_placement();
    test_random_traffic();
    if (in_valid) in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("positional_list_buffer verification clean");
    end else begin
      $display("positional_list_buffer verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/plb_pkg.sv
rtl/plb_cell.sv
rtl/positional_list_buffer.sv
tb/testbench.sv
